/* hw/rtl/usbsg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usbsg_pkg
// Shared types, sizes and codes for the bulk IN frame segmenter.
// ----------------------------------------------------------------------------
package usbsg_pkg;

  localparam int RING_DEPTH      = 4;
  localparam int PACKET_BYTES    = 64;
  localparam int FRAME_BYTES_MAX = 1536;
  localparam int ADDR_W          = 32;
  localparam int LEN_W           = 11;
  localparam int PLEN_W          = 7;
  localparam int MODE_W          = 2;
  localparam int IDX_W           = $clog2(RING_DEPTH);
  localparam int CNT_W           = $clog2(RING_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_POST      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READY     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP       = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BUS_RESET = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] frame_address;
    logic [LEN_W-1:0]  frame_length;
    logic              data_pending;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              packet_valid;
    logic [ADDR_W-1:0] packet_address;
    logic [PLEN_W-1:0] packet_length;
    logic              completed_valid;
    logic [LEN_W-1:0]  completed_length;
    logic              nak_enable;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic              pending;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] active;
    logic [CNT_W-1:0] finished;
  } ring_status_t;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cnt);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(idx) + (CNT_W+1)'(cnt);
    if (s >= (CNT_W+1)'(RING_DEPTH)) s = s - (CNT_W+1)'(RING_DEPTH);
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_sub(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cnt);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(idx) + (CNT_W+1)'(RING_DEPTH) - (CNT_W+1)'(cnt);
    if (s >= (CNT_W+1)'(RING_DEPTH)) s = s - (CNT_W+1)'(RING_DEPTH);
    return s[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/usbsg_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usbsg_front
// Accepts items, saturates the frame length and queues commands for the back.
// ----------------------------------------------------------------------------
module usbsg_front
  import usbsg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          cmd_valid,
  output cmd_t          cmd,
  input  wire logic     cmd_take
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  cmd_t       cls;

  always_comb begin
    cls.mode    = in_data.mode;
    cls.address = in_data.frame_address;
    cls.pending = in_data.data_pending;
    if (in_data.frame_length > LEN_W'(FRAME_BYTES_MAX)) begin
      cls.length = LEN_W'(FRAME_BYTES_MAX);
    end else begin
      cls.length = in_data.frame_length;
    end
  end

  assign in_stall  = (count_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_take ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(cmd_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/usbsg_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usbsg_back
// Descriptor ring state, packet segmentation and the result register.
// ----------------------------------------------------------------------------
module usbsg_back
  import usbsg_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   cmd_valid,
  input  wire cmd_t   cmd,
  output logic        cmd_take,
  output logic        out_valid,
  input  wire logic   out_stall,
  output out_item_t   out_data,
  output ring_status_t status
);

  logic [ADDR_W-1:0] entry_addr_r [RING_DEPTH];
  logic [LEN_W-1:0]  entry_len_r  [RING_DEPTH];
  logic [LEN_W-1:0]  done_len_r   [RING_DEPTH];

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] active_r, active_nxt;
  logic [CNT_W-1:0] finished_r, finished_nxt;
  logic [LEN_W-1:0] head_off_r, head_off_nxt;
  logic             nak_r, nak_nxt;
  logic             out_valid_r;
  out_item_t        out_r;

  out_item_t        res;
  logic             post_we, fin_we;
  logic [IDX_W-1:0] tail_idx, first_idx;
  logic [CNT_W:0]   occ;
  logic [LEN_W-1:0] left;
  logic             short_pkt;
  logic [PLEN_W-1:0] n;

  assign cmd_take  = cmd_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign status    = '{active: active_r, finished: finished_r};

  assign tail_idx  = ring_add(head_r, active_r);
  assign first_idx = ring_sub(head_r, finished_r);
  assign occ       = (CNT_W+1)'(active_r) + (CNT_W+1)'(finished_r);
  assign left      = entry_len_r[head_r] - head_off_r;
  assign short_pkt = left < LEN_W'(PACKET_BYTES);
  assign n         = short_pkt ? left[PLEN_W-1:0] : PLEN_W'(PACKET_BYTES);

  always_comb begin
    head_nxt     = head_r;
    active_nxt   = active_r;
    finished_nxt = finished_r;
    head_off_nxt = head_off_r;
    nak_nxt      = nak_r;
    post_we      = 1'b0;
    fin_we       = 1'b0;
    res          = '0;
    unique case (cmd.mode)
      MODE_POST: begin
        if (occ < (CNT_W+1)'(RING_DEPTH)) begin
          post_we      = 1'b1;
          active_nxt   = active_r + CNT_W'(1);
          nak_nxt      = 1'b1;
          res.accepted = 1'b1;
        end
      end
      MODE_READY: begin
        if (active_r == '0) begin
          nak_nxt = 1'b0;
        end else if (!cmd.pending) begin
          res.packet_valid   = 1'b1;
          res.packet_address = entry_addr_r[head_r] + ADDR_W'(head_off_r);
          res.packet_length  = n;
          if (short_pkt) begin
            fin_we       = 1'b1;
            head_nxt     = ring_add(head_r, CNT_W'(1));
            active_nxt   = active_r - CNT_W'(1);
            finished_nxt = finished_r + CNT_W'(1);
            head_off_nxt = '0;
          end else begin
            head_off_nxt = head_off_r + LEN_W'(n);
          end
        end
      end
      MODE_POP: begin
        if (finished_r != '0) begin
          res.completed_valid  = 1'b1;
          res.completed_length = done_len_r[first_idx];
          finished_nxt         = finished_r - CNT_W'(1);
        end
      end
      MODE_BUS_RESET: begin
        if (active_r != '0) begin
          head_off_nxt = '0;
          nak_nxt      = 1'b1;
        end else begin
          nak_nxt = 1'b0;
        end
      end
      default: ;
    endcase
    res.nak_enable = nak_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      active_r    <= '0;
      finished_r  <= '0;
      head_off_r  <= '0;
      nak_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_take) begin
        head_r     <= head_nxt;
        active_r   <= active_nxt;
        finished_r <= finished_nxt;
        head_off_r <= head_off_nxt;
        nak_r      <= nak_nxt;
      end
      if (cmd_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      out_r <= res;
    end
    if (cmd_take && post_we) begin
      entry_addr_r[tail_idx] <= cmd.address;
      entry_len_r[tail_idx]  <= cmd.length;
    end
    if (cmd_take && fin_we) begin
      done_len_r[head_r] <= entry_len_r[head_r];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/usb_bulk_in_frame_segmenter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usb_bulk_in_frame_segmenter
// Transmit descriptor ring that cuts posted frames into bulk IN packets.
// ----------------------------------------------------------------------------
// Each accepted item yields exactly one result item. The block sustains one
// item per clock when the output is not stalled: the front registers items
// into a two-entry command queue, and the back executes one command per cycle
// against the ring and loads the result register, so an item is registered in
// the command queue and its result then in the result register. The queue lets
// the input keep taking up to two items while a result waits on the output.
module usb_bulk_in_frame_segmenter
  import usbsg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic         cmd_valid;
  cmd_t         cmd;
  logic         cmd_take;
  ring_status_t status;

  usbsg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  usbsg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (status)
  );

`ifndef SYNTH
  a_ring_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    ((CNT_W+1)'(status.active) + (CNT_W+1)'(status.finished))
      <= (CNT_W+1)'(RING_DEPTH))
    else $error("ring occupancy exceeds depth");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_data.accepted, out_data.packet_valid,
                            out_data.completed_valid}))
    else $error("result reports more than one kind of event");

  a_packet_nak: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.packet_valid) |-> out_data.nak_enable)
    else $error("packet issued with NAK enable clear");

  a_packet_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.packet_valid)
      |-> (out_data.packet_length <= PLEN_W'(PACKET_BYTES)))
    else $error("packet longer than max packet size");
`endif

endmodule
`default_nettype wire

/* tb/tb_usb_bulk_in_frame_segmenter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_usb_bulk_in_frame_segmenter
// The testbench posts frames, issues endpoint-ready, pop and bus reset items,
// and predicts every result from its own copy of the descriptor ring. Each
// result is compared field by field. The sender runs in random bursts and
// gaps, and the output stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_usb_bulk_in_frame_segmenter;
  import usbsg_pkg::*;

  localparam int RANDOM_ITEMS = 1580;

  class frame_ring_checker;
    logic [ADDR_W-1:0] ring_addr [RING_DEPTH];
    logic [LEN_W-1:0]  ring_len  [RING_DEPTH];
    logic [LEN_W-1:0]  ring_off  [RING_DEPTH];
    int                head;
    int                active;
    int                finished;
    logic              nak;
    out_item_t         pending_results [$];
    int                errors;

    function new();
      head     = 0;
      active   = 0;
      finished = 0;
      nak      = 1'b0;
      errors   = 0;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void record_item(in_item_t it);
      out_item_t        r;
      int               slot;
      int               left;
      int               n;
      logic [LEN_W-1:0] flen;
      r = '0;
      case (it.mode)
        MODE_POST: begin
          if (active + finished < RING_DEPTH) begin
            slot = (head + active) % RING_DEPTH;
            flen = (it.frame_length > FRAME_BYTES_MAX) ? LEN_W'(FRAME_BYTES_MAX)
                                                       : it.frame_length;
            ring_addr[slot] = it.frame_address;
            ring_len[slot]  = flen;
            ring_off[slot]  = '0;
            active++;
            r.accepted = 1'b1;
            nak = 1'b1;
          end
        end
        MODE_READY: begin
          if (active == 0) begin
            nak = 1'b0;
          end else if (!it.data_pending) begin
            left = int'(ring_len[head]) - int'(ring_off[head]);
            n = (left < PACKET_BYTES) ? left : PACKET_BYTES;
            r.packet_valid   = 1'b1;
            r.packet_address = ring_addr[head] + ADDR_W'(ring_off[head]);
            r.packet_length  = PLEN_W'(n);
            ring_off[head] = ring_off[head] + LEN_W'(n);
            if (ring_off[head] == ring_len[head] && n < PACKET_BYTES) begin
              head = (head + 1) % RING_DEPTH;
              active--;
              finished++;
            end
          end
        end
        MODE_POP: begin
          if (finished != 0) begin
            slot = (head + RING_DEPTH - finished) % RING_DEPTH;
            r.completed_valid  = 1'b1;
            r.completed_length = ring_off[slot];
            finished--;
          end
        end
        default: begin
          if (active > 0) begin
            ring_off[head] = '0;
            nak = 1'b1;
          end else begin
            nak = 1'b0;
          end
        end
      endcase
      r.nak_enable = nak;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %0h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("packet_valid", want.packet_valid, got.packet_valid);
      compare_field("packet_address", want.packet_address, got.packet_address);
      compare_field("packet_length", want.packet_length, got.packet_length);
      compare_field("completed_valid", want.completed_valid, got.completed_valid);
      compare_field("completed_length", want.completed_length, got.completed_length);
      compare_field("nak_enable", want.nak_enable, got.nak_enable);
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  frame_ring_checker sb;
  in_item_t          item_plan [$];

  usb_bulk_in_frame_segmenter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic in_item_t make_item(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a,
                                         logic [LEN_W-1:0] l, logic p);
    in_item_t it;
    it.mode          = m;
    it.frame_address = a;
    it.frame_length  = l;
    it.data_pending  = p;
    return it;
  endfunction

  function automatic logic [LEN_W-1:0] random_length();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel <= 9) return LEN_W'($urandom_range(1, 130));
    if (sel <= 12) return LEN_W'(PACKET_BYTES * $urandom_range(1, 4));
    if (sel <= 15) return LEN_W'($urandom_range(131, 700));
    if (sel == 16) return LEN_W'(FRAME_BYTES_MAX);
    if (sel == 17) return LEN_W'($urandom_range(FRAME_BYTES_MAX + 1, 2047));
    if (sel == 18) return LEN_W'($urandom_range(0, 2047));
    return LEN_W'(PACKET_BYTES);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    it.frame_address = $urandom();
    it.frame_length  = random_length();
    it.data_pending  = ($urandom_range(0, 5) == 0);
    if (pick < 26) it.mode = MODE_POST;
    else if (pick < 82) it.mode = MODE_READY;
    else if (pick < 98) it.mode = MODE_POP;
    else it.mode = MODE_BUS_RESET;
    return it;
  endfunction

  task automatic build_plan();
    int k;
    item_plan.push_back(make_item(MODE_READY, '0, '0, 1'b0));
    item_plan.push_back(make_item(MODE_POP, '1, '1, 1'b1));
    item_plan.push_back(make_item(MODE_BUS_RESET, '0, '0, 1'b0));
    item_plan.push_back(make_item(MODE_POST, 32'hFFFF_FFF0, 11'd100, 1'b0));
    item_plan.push_back(make_item(MODE_READY, '0, '0, 1'b1));
    item_plan.push_back(make_item(MODE_READY, '0, '0, 1'b0));
    item_plan.push_back(make_item(MODE_BUS_RESET, '1, '1, 1'b1));
    item_plan.push_back(make_item(MODE_READY, '0, '0, 1'b0));
    item_plan.push_back(make_item(MODE_READY, '0, '0, 1'b0));
    item_plan.push_back(make_item(MODE_POST, '0, '0, 1'b0));
    item_plan.push_back(make_item(MODE_POST, 32'h1234_5678, 11'd64, 1'b1));
    item_plan.push_back(make_item(MODE_POST, 32'hA5A5_A5A5, 11'd2047, 1'b0));
    item_plan.push_back(make_item(MODE_POST, '0, 11'd1536, 1'b0));
    item_plan.push_back(make_item(MODE_POP, '0, '0, 1'b0));
    item_plan.push_back(make_item(MODE_POST, 32'h5A5A_5A5A, 11'd1536, 1'b0));
    item_plan.push_back(make_item(MODE_POST, '1, 11'd5, 1'b0));
    item_plan.push_back(make_item(MODE_READY, '0, '0, 1'b0));
    item_plan.push_back(make_item(MODE_READY, '0, '0, 1'b0));
    item_plan.push_back(make_item(MODE_READY, '0, '0, 1'b0));
    item_plan.push_back(make_item(MODE_POP, '0, '0, 1'b0));
    item_plan.push_back(make_item(MODE_POP, '0, '0, 1'b0));
    item_plan.push_back(make_item(MODE_POP, '0, '0, 1'b0));
    for (k = 0; k < RANDOM_ITEMS; k++) item_plan.push_back(random_item());
  endtask

  task automatic send_item(input in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.record_item(it);
  endtask

  task automatic drive_plan();
    int i;
    int burst;
    int gap;
    burst = 0;
    for (i = 0; i < item_plan.size(); i++) begin
      if (i % 400 == 22) begin
        // hold off until the ring has answered everything
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
      end else if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      if (burst == 0) burst = $urandom_range(1, 24);
      send_item(item_plan[i]);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  initial begin : stall_pattern
    int kind;
    int span;
    int n;
    wait (rst_n);
    forever begin
      kind = $urandom_range(0, 3);
      span = (kind == 3) ? $urandom_range(1, 10) : $urandom_range(4, 40);
      for (n = 0; n < span; n++) begin
        @(posedge clk);
        case (kind)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= (n % 3 == 1);
          default: out_stall <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin : main
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    build_plan();
    drive_plan();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
